[sv/dtsq_pkg.sv]
`default_nettype none

package dtsq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int ENTRY_W       = 64;
  localparam int SET_W         = 12;
  localparam int INDEX_W       = 6;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_INVALID   = 3'd5;
  localparam logic [2:0] ST_MATCH     = 3'd6;
  localparam logic [2:0] ST_NO_MATCH  = 3'd7;

  typedef struct packed {
    logic [1:0]         mode;
    logic [ENTRY_W-1:0] entry_value;
    logic [SET_W-1:0]   query_set;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [INDEX_W-1:0] match_index;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

[sv/dtsq_mem.sv]
`default_nettype none

module dtsq_mem import dtsq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [ENTRY_W-1:0] wdata,
  input  wire logic [AW-1:0]      raddr,
  output logic      [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/dtsq_ctrl.sv]
`default_nettype none

module dtsq_ctrl import dtsq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire cmd_t               cmd,
  output logic                    result_valid,
  output result_t                 result,
  output logic      [AW-1:0]      rd_addr,
  input  wire logic [ENTRY_W-1:0] rd_data,
  output logic                    wr_en,
  output logic      [AW-1:0]      wr_addr,
  output logic      [ENTRY_W-1:0] wr_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic          state;
  cmd_t          cmd_q;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;
  logic          hit;
  logic          pend_valid;
  logic [AW-1:0] pend_idx;

  logic issue;
  logic eq;
  logic subset;

  assign busy    = (state == S_SCAN);
  assign rd_addr = idx[AW-1:0];
  assign issue   = (idx < count);

  // the shared compare unit: one stored entry per cycle
  assign eq     = (rd_data == cmd_q.entry_value);
  assign subset = ((rd_data[SET_W-1:0] & ~cmd_q.query_set) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
      wr_en        <= 1'b0;
      cmp_valid    <= 1'b0;
      pend_valid   <= 1'b0;
      hit          <= 1'b0;
      idx          <= '0;
    end else begin
      result_valid <= 1'b0;
      wr_en        <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q              <= cmd;
            idx                <= '0;
            cmp_valid          <= 1'b0;
            hit                <= 1'b0;
            pend_valid         <= 1'b0;
            result.match_index <= '0;
            result.last        <= 1'b1;
            case (cmd.mode)
              MODE_INSERT: begin
                if (cmd.entry_value == '0) begin
                  // zero skips the duplicate check
                  result_valid <= 1'b1;
                  if (count == FULL_COUNT) begin
                    result.status <= ST_FULL;
                  end else begin
                    result.status <= ST_INSERTED;
                    wr_en         <= 1'b1;
                    wr_addr       <= count[AW-1:0];
                    wr_data       <= cmd.entry_value;
                    count         <= count + 1'b1;
                  end
                end else begin
                  state <= S_SCAN;
                end
              end
              MODE_LOOKUP: begin
                if (cmd.entry_value == '0) begin
                  result_valid  <= 1'b1;
                  result.status <= ST_INVALID;
                end else begin
                  state <= S_SCAN;
                end
              end
              MODE_QUERY: begin
                if (cmd.query_set == '0) begin
                  result_valid  <= 1'b1;
                  result.status <= ST_INVALID;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                result_valid  <= 1'b1;
                result.status <= ST_INVALID;
              end
            endcase
          end
        end
        S_SCAN: begin
          // advance the read pointer while stored entries remain
          cmp_valid <= issue;
          cmp_idx   <= idx[AW-1:0];
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (cmp_valid) begin
            if (eq) begin
              hit <= 1'b1;
            end
            if (cmd_q.mode == MODE_QUERY && subset) begin
              // release the previous match, hold this one back
              if (pend_valid) begin
                result_valid       <= 1'b1;
                result.status      <= ST_MATCH;
                result.match_index <= INDEX_W'(pend_idx);
                result.last        <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_idx   <= cmp_idx;
            end
          end else if (!issue) begin
            // scan finished: settle the item
            state              <= S_IDLE;
            result_valid       <= 1'b1;
            result.match_index <= '0;
            result.last        <= 1'b1;
            case (cmd_q.mode)
              MODE_INSERT: begin
                if (hit) begin
                  result.status <= ST_DUPLICATE;
                end else if (count == FULL_COUNT) begin
                  result.status <= ST_FULL;
                end else begin
                  result.status <= ST_INSERTED;
                  wr_en         <= 1'b1;
                  wr_addr       <= count[AW-1:0];
                  wr_data       <= cmd_q.entry_value;
                  count         <= count + 1'b1;
                end
              end
              MODE_LOOKUP: begin
                result.status <= hit ? ST_FOUND : ST_NOT_FOUND;
              end
              default: begin
                if (pend_valid) begin
                  result.status      <= ST_MATCH;
                  result.match_index <= INDEX_W'(pend_idx);
                end else begin
                  result.status <= ST_NO_MATCH;
                end
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/dedup_table_with_subset_query_top.sv]
`default_nettype none

// Deduplicating entry table with subset query. A transaction is taken on a
// rising edge where start is high and busy is low. Insert, lookup and query
// each walk the stored entries through a single compare unit fed by the
// table memory's one read port, one entry per cycle, and the block stays
// busy until the walk is through and the item is settled; an insert of
// zero, an invalid item and an unused mode settle from idle with no walk.
// Results appear on result for exactly one cycle each, marked by
// result_valid; the receiver cannot stall them and must take every one.
// A query yields its matches in ascending index order, one per cycle at
// most, with last set on the final one; every transaction ends with a
// result whose last bit is set. No clearing pass runs after reset: only
// entries below the fill count are ever read.

module dedup_table_with_subset_query_top import dtsq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd,
  output logic      result_valid,
  output result_t   result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // table memory port signals
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // sequencer and compare unit: drives the scan and settles each item
  dtsq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // entry store, filled in insertion order
  dtsq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire
